/* src/fpd_pkg.sv */
// ----------------------------------------------------------------------------
// fpd_pkg: shared types and constants of the fuzzy PD velocity controller
// Command codes, register indexes, register reset values, datapath widths
// and the small min/max helpers used by the rule evaluation.
// ----------------------------------------------------------------------------
package fpd_pkg;

   localparam int MOTOR_COUNT_DEF = 2;
   localparam int TICK_LIMIT_DEF  = 2047;
   localparam int PWM_MAX_DEF     = 255;

   localparam int CMD_W     = 2;
   localparam int TARGET_W  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;
   localparam int GAIN_W    = 8;
   localparam int GAIN_N    = 6;
   localparam int GAIN_IDX_W = 3;
   localparam int MEMB_W    = 7;
   localparam int WSUM_W    = 9;
   localparam int WMUL_W    = 17;
   localparam int VEL_OUT_W = 9;
   localparam int PWM_OUT_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_EDGE   = 2'd0,
      CMD_TARGET = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] REG_KP_SMALL     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KP_MEDIUM    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KP_LARGE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KD_SMALL     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KD_MEDIUM    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KD_LARGE     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_LIMIT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MEMB_SPAN    = 3'd7;

   typedef logic [GAIN_W-1:0] gain_array_type [GAIN_N];

   localparam gain_array_type GAIN_RESET = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd11};
   localparam logic [MEMB_W-1:0] TARGET_LIMIT_RESET = 7'd120;
   localparam logic [MEMB_W-1:0] MEMB_SPAN_RESET    = 7'd10;

   typedef struct packed {
      logic [MEMB_W-1:0] n;
      logic [MEMB_W-1:0] z;
      logic [MEMB_W-1:0] p;
   } memb_type;

   function automatic logic [MEMB_W-1:0] mmin(input logic [MEMB_W-1:0] a,
                                              input logic [MEMB_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [MEMB_W-1:0] mmax(input logic [MEMB_W-1:0] a,
                                              input logic [MEMB_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

/* src/fpd_divider.sv */
// ----------------------------------------------------------------------------
// fpd_divider: iterative restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpd_divider #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             busy,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] count_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W:0]   trial;
   logic             take;

   assign trial  = {rem_ff, quo_ff[NUM_W-1]};
   assign take   = (trial >= {1'b0, den_ff});
   assign rem_in = take ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= CNT_W'(NUM_W);
      end else if (count_ff != '0) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (count_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[NUM_W-2:0], take};
      end
   end

   assign busy     = (count_ff != '0);
   assign quotient = quo_ff;

endmodule

/* src/fuzzy_pd_motor_velocity_controller.sv */
// ----------------------------------------------------------------------------
// fuzzy_pd_motor_velocity_controller: fuzzy PD velocity loop for several motors
// The req channel takes encoder edges, target updates and sample ticks. Edges
// and targets are absorbed and give no result. A sample tick gives one rsp item
// per motor, motor 0 first, with last set on the final one. Each tick runs a
// small sequencer over one shared multiplier and one restoring divider: per
// motor two subtracts, fuzzification, the rule matrix, six multiply-accumulate
// steps and two multiply/divide pairs. The error difference is DW bits wide
// (14 with the default tick limit), and the divider gives one quotient bit per
// cycle. req_stall stays high from a tick until its last item is in the output
// register.
// The output register holds one item; while rsp_stall is high it holds it
// and the next motor's computation stops before its own result.
// Synchronous reset clears counts, targets, history and velocities, and loads
// the register reset values. The csr port is always ready.
// ----------------------------------------------------------------------------
module fuzzy_pd_motor_velocity_controller
   import fpd_pkg::*;
#(
   parameter int MOTOR_COUNT = MOTOR_COUNT_DEF,
   parameter int TICK_LIMIT  = TICK_LIMIT_DEF,
   parameter int PWM_MAX     = PWM_MAX_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [CMD_W-1:0]            req_cmd,
   input  logic                        req_motor,
   input  logic                        req_count_up,
   input  logic signed [TARGET_W-1:0]  req_target_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_motor_id,
   output logic [PWM_OUT_W-1:0]        rsp_pwm_forward,
   output logic [PWM_OUT_W-1:0]        rsp_pwm_reverse,
   output logic signed [VEL_OUT_W-1:0] rsp_velocity,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DAT_W-1:0]        csr_data
);

   localparam int TW    = $clog2(TICK_LIMIT + 1) + 1;
   localparam int EW    = $clog2(TICK_LIMIT + 128) + 1;
   localparam int DW    = EW + 1;
   localparam int PW    = DW + WMUL_W + 1;
   localparam int MAGW  = DW + 16;
   localparam int CW    = DW + 9;
   localparam int VW    = $clog2(PWM_MAX + 1) + 1;
   localparam int SW    = ((CW > VW) ? CW : VW) + 1;
   localparam int MIW   = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ERR,
      S_DEL,
      S_FUZZ,
      S_RULE,
      S_MAC,
      S_PMUL,
      S_PDIV_GO,
      S_PDIV_WAIT,
      S_DMUL,
      S_DDIV_GO,
      S_DDIV_WAIT,
      S_VEL
   } state_type;

   state_type state_ff;

   gain_array_type    gain_ff;
   logic [MEMB_W-1:0] limit_ff;
   logic [MEMB_W-1:0] span_ff;

   logic signed [TW-1:0]       tick_ff     [MOTOR_COUNT];
   logic signed [TARGET_W-1:0] target_ff   [MOTOR_COUNT];
   logic signed [EW-1:0]       prev_err_ff [MOTOR_COUNT];
   logic signed [CW-1:0]       corr_ff     [MOTOR_COUNT];
   logic signed [VW-1:0]       vel_ff      [MOTOR_COUNT];

   logic [MIW-1:0]          cur_ff;
   logic signed [EW-1:0]    err_ff;
   logic signed [DW-1:0]    del_ff;
   memb_type                me_ff;
   memb_type                md_ff;
   logic [MEMB_W-1:0]       w_ff [GAIN_N];
   logic [GAIN_IDX_W-1:0]   k_ff;
   logic [WMUL_W-1:0]       pmul_ff;
   logic [WMUL_W-1:0]       dmul_ff;
   logic [WSUM_W-1:0]       psum_ff;
   logic [WSUM_W-1:0]       dsum_ff;
   logic                    neg_ff;
   logic [MAGW-1:0]         mag_ff;
   logic signed [CW-1:0]    qp_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_motor_id_ff;
   logic [PWM_OUT_W-1:0]        rsp_pwm_forward_ff;
   logic [PWM_OUT_W-1:0]        rsp_pwm_reverse_ff;
   logic signed [VEL_OUT_W-1:0] rsp_velocity_ff;
   logic                        rsp_last_ff;

   logic                    req_take;
   logic                    motor_ok;
   logic [MIW-1:0]          req_idx;
   logic signed [TW-1:0]    tick_in;
   logic signed [TARGET_W:0] tv_wide;
   logic signed [TARGET_W:0] lim_wide;
   logic signed [TARGET_W-1:0] target_in;
   logic signed [EW-1:0]    err_in;
   logic signed [DW-1:0]    del_in;
   memb_type                me_in;
   memb_type                md_in;
   logic [MEMB_W-1:0]       r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic [MEMB_W-1:0]       w_in [GAIN_N];
   logic signed [DW-1:0]    mul_a;
   logic [WMUL_W-1:0]       mul_b;
   logic signed [PW-1:0]    mul_p;
   logic signed [PW-1:0]    mul_abs;
   logic                    div_start;
   logic [WSUM_W-1:0]       div_den;
   logic                    div_busy;
   logic [MAGW-1:0]         div_quot;
   logic signed [CW-1:0]    q_signed;
   logic signed [SW-1:0]    vsum;
   logic signed [SW-1:0]    pmax;
   logic signed [VW-1:0]    vel_in;
   logic signed [VW-1:0]    vel_neg;
   logic                    out_free;
   logic                    out_load;
   logic                    cur_last;

   function automatic memb_type fuzzify(input logic signed [DW-1:0] v,
                                        input logic [MEMB_W-1:0]   span);
      logic signed [DW-1:0] sp;
      logic signed [DW-1:0] mag;
      memb_type             m;
      sp  = $signed(DW'(span));
      mag = (v < 0) ? -v : v;
      m   = '0;
      if (v > sp) begin
         m.p = span;
      end else if (v < -sp) begin
         m.n = span;
      end else if (v > 0) begin
         m.p = mag[MEMB_W-1:0];
         m.z = span - mag[MEMB_W-1:0];
      end else begin
         m.n = mag[MEMB_W-1:0];
         m.z = span - mag[MEMB_W-1:0];
      end
      return m;
   endfunction

   // Input side.
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign motor_ok  = (MOTOR_COUNT > 1) || !req_motor;
   assign req_idx   = MIW'(req_motor);

   always_comb begin
      tick_in = tick_ff[req_idx];
      if (req_count_up) begin
         if (tick_ff[req_idx] < TW'(TICK_LIMIT)) begin
            tick_in = tick_ff[req_idx] + 1'b1;
         end
      end else begin
         if (tick_ff[req_idx] > -TW'(TICK_LIMIT)) begin
            tick_in = tick_ff[req_idx] - 1'b1;
         end
      end
   end

   assign tv_wide  = (TARGET_W + 1)'(req_target_value);
   assign lim_wide = $signed((TARGET_W + 1)'(limit_ff));

   always_comb begin
      if (tv_wide > lim_wide) begin
         target_in = TARGET_W'(lim_wide);
      end else if (tv_wide < -lim_wide) begin
         target_in = TARGET_W'(-lim_wide);
      end else begin
         target_in = req_target_value;
      end
   end

   // Error, difference, memberships and rule weights.
   assign err_in = EW'(target_ff[cur_ff]) - EW'(tick_ff[cur_ff]);
   assign del_in = DW'(err_ff) - DW'(prev_err_ff[cur_ff]);
   assign me_in  = fuzzify(DW'(err_ff), span_ff);
   assign md_in  = fuzzify(del_ff, span_ff);

   assign r00 = mmin(me_ff.n, md_ff.n);
   assign r01 = mmin(me_ff.n, md_ff.z);
   assign r02 = mmin(me_ff.n, md_ff.p);
   assign r10 = mmin(me_ff.z, md_ff.n);
   assign r11 = mmin(me_ff.z, md_ff.z);
   assign r12 = mmin(me_ff.z, md_ff.p);
   assign r20 = mmin(me_ff.p, md_ff.n);
   assign r21 = mmin(me_ff.p, md_ff.z);
   assign r22 = mmin(me_ff.p, md_ff.p);

   assign w_in[0] = r11;
   assign w_in[1] = mmax(mmax(mmax(r10, r01), mmax(r21, r12)), mmax(r00, r22));
   assign w_in[2] = mmax(r02, r20);
   assign w_in[3] = mmax(mmax(r02, r20), r11);
   assign w_in[4] = mmax(mmax(r00, r01), mmax(r21, r22));
   assign w_in[5] = mmax(r10, r12);

   // Shared multiplier.
   always_comb begin
      unique case (state_ff)
         S_PMUL: begin
            mul_a = DW'(err_ff);
            mul_b = pmul_ff;
         end
         S_DMUL: begin
            mul_a = del_ff;
            mul_b = dmul_ff;
         end
         default: begin
            mul_a = $signed(DW'(w_ff[k_ff]));
            mul_b = WMUL_W'(gain_ff[k_ff]);
         end
      endcase
   end

   assign mul_p   = PW'(mul_a) * $signed(PW'(mul_b));
   assign mul_abs = (mul_p < 0) ? -mul_p : mul_p;

   // Shared divider.
   assign div_start = (state_ff == S_PDIV_GO) || (state_ff == S_DDIV_GO);
   assign div_den   = (state_ff == S_PDIV_GO) ? psum_ff : dsum_ff;

   fpd_divider #(
      .NUM_W (MAGW),
      .DEN_W (WSUM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   assign q_signed = neg_ff ? -$signed(CW'(div_quot)) : $signed(CW'(div_quot));

   // Velocity accumulation and output.
   assign vsum = SW'(vel_ff[cur_ff]) + SW'(corr_ff[cur_ff]);
   assign pmax = SW'(PWM_MAX);

   always_comb begin
      if (vsum > pmax) begin
         vel_in = VW'(pmax);
      end else if (vsum < -pmax) begin
         vel_in = VW'(-pmax);
      end else begin
         vel_in = VW'(vsum);
      end
   end

   assign vel_neg  = -vel_in;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == S_VEL) && out_free;
   assign cur_last = (cur_ff == MIW'(MOTOR_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         k_ff         <= '0;
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            tick_ff[i]     <= '0;
            target_ff[i]   <= '0;
            prev_err_ff[i] <= '0;
            corr_ff[i]     <= '0;
            vel_ff[i]      <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall && !out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  priority if (req_cmd == CMD_EDGE) begin
                     if (motor_ok) begin
                        tick_ff[req_idx] <= tick_in;
                     end
                  end else if (req_cmd == CMD_TARGET) begin
                     if (motor_ok) begin
                        target_ff[req_idx] <= target_in;
                     end
                  end else if (req_cmd == CMD_TICK) begin
                     cur_ff   <= '0;
                     state_ff <= S_ERR;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_ERR: begin
               err_ff   <= err_in;
               state_ff <= S_DEL;
            end
            S_DEL: begin
               del_ff              <= del_in;
               prev_err_ff[cur_ff] <= err_ff;
               tick_ff[cur_ff]     <= '0;
               state_ff            <= S_FUZZ;
            end
            S_FUZZ: begin
               me_ff    <= me_in;
               md_ff    <= md_in;
               state_ff <= S_RULE;
            end
            S_RULE: begin
               for (int i = 0; i < GAIN_N; i++) begin
                  w_ff[i] <= w_in[i];
               end
               pmul_ff  <= '0;
               dmul_ff  <= '0;
               psum_ff  <= '0;
               dsum_ff  <= '0;
               k_ff     <= '0;
               state_ff <= S_MAC;
            end
            S_MAC: begin
               if (k_ff < GAIN_IDX_W'(GAIN_N / 2)) begin
                  pmul_ff <= pmul_ff + WMUL_W'(mul_p);
                  psum_ff <= psum_ff + WSUM_W'(w_ff[k_ff]);
               end else begin
                  dmul_ff <= dmul_ff + WMUL_W'(mul_p);
                  dsum_ff <= dsum_ff + WSUM_W'(w_ff[k_ff]);
               end
               k_ff <= k_ff + 1'b1;
               if (k_ff == GAIN_IDX_W'(GAIN_N - 1)) begin
                  state_ff <= S_PMUL;
               end
            end
            S_PMUL: begin
               neg_ff   <= (mul_p < 0);
               mag_ff   <= MAGW'(mul_abs);
               state_ff <= S_PDIV_GO;
            end
            S_PDIV_GO: begin
               state_ff <= S_PDIV_WAIT;
            end
            S_PDIV_WAIT: begin
               if (!div_busy) begin
                  qp_ff    <= q_signed;
                  state_ff <= S_DMUL;
               end
            end
            S_DMUL: begin
               neg_ff   <= (mul_p < 0);
               mag_ff   <= MAGW'(mul_abs);
               state_ff <= S_DDIV_GO;
            end
            S_DDIV_GO: begin
               state_ff <= S_DDIV_WAIT;
            end
            S_DDIV_WAIT: begin
               if (!div_busy) begin
                  if ((psum_ff != '0) && (dsum_ff != '0)) begin
                     corr_ff[cur_ff] <= qp_ff + q_signed;
                  end
                  state_ff <= S_VEL;
               end
            end
            S_VEL: begin
               if (out_free) begin
                  vel_ff[cur_ff]   <= vel_in;
                  rsp_valid_ff     <= 1'b1;
                  rsp_motor_id_ff  <= cur_ff[0];
                  rsp_velocity_ff  <= VEL_OUT_W'(vel_in);
                  rsp_last_ff      <= cur_last;
                  if (vel_in < 0) begin
                     rsp_pwm_forward_ff <= '0;
                     rsp_pwm_reverse_ff <= PWM_OUT_W'(vel_neg);
                  end else begin
                     rsp_pwm_forward_ff <= PWM_OUT_W'(vel_in);
                     rsp_pwm_reverse_ff <= '0;
                  end
                  if (cur_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     cur_ff   <= cur_ff + 1'b1;
                     state_ff <= S_ERR;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         limit_ff <= TARGET_LIMIT_RESET;
         span_ff  <= MEMB_SPAN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TARGET_LIMIT: limit_ff <= csr_data[MEMB_W-1:0];
            REG_MEMB_SPAN:    span_ff  <= csr_data[MEMB_W-1:0];
            default:          gain_ff[csr_index] <= csr_data;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_motor_id    = rsp_motor_id_ff;
   assign rsp_pwm_forward = rsp_pwm_forward_ff;
   assign rsp_pwm_reverse = rsp_pwm_reverse_ff;
   assign rsp_velocity    = rsp_velocity_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fuzzy_pd_motor_velocity_controller
// Sends encoder edges, target updates, sample ticks and unused commands, and
// keeps its own fuzzy PD model of both motors. Each sample tick queues one
// expected drive item per motor, and every rsp item is checked field by field
// against the oldest one. Runs go through several register settings,
// including the extremes and a zero membership span, and through phases of
// random sender gaps, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import fpd_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_CYCLES  = 200;
   localparam int REPORT_LIMIT  = 10;
   localparam int EDGE_RUN      = 60;
   localparam int PHASE_ITEMS   = 155;
   localparam int HOLD_CYCLES   = 1500;

   typedef struct {
      logic                        motor_id;
      logic [PWM_OUT_W-1:0]        pwm_forward;
      logic [PWM_OUT_W-1:0]        pwm_reverse;
      logic signed [VEL_OUT_W-1:0] velocity;
      logic                        last;
   } drive_type;

   typedef logic [CSR_DAT_W-1:0] reg_set_type [8];

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [CMD_W-1:0]            req_cmd = CMD_EDGE;
   logic                        req_motor = 1'b0;
   logic                        req_count_up = 1'b0;
   logic signed [TARGET_W-1:0]  req_target_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_motor_id;
   logic [PWM_OUT_W-1:0]        rsp_pwm_forward;
   logic [PWM_OUT_W-1:0]        rsp_pwm_reverse;
   logic signed [VEL_OUT_W-1:0] rsp_velocity;
   logic                        rsp_last;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DAT_W-1:0]        csr_data = '0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_length = 0;
   int hold_serial = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int error_count = 0;

   logic [CSR_DAT_W-1:0]        cfg_reg [8];
   logic signed [11:0]          tick_count [MOTOR_COUNT_DEF];
   logic signed [TARGET_W-1:0]  target_ticks [MOTOR_COUNT_DEF];
   logic signed [12:0]          prev_error [MOTOR_COUNT_DEF];
   longint                      last_correction [MOTOR_COUNT_DEF];
   logic signed [VEL_OUT_W-1:0] velocity_accum [MOTOR_COUNT_DEF];
   drive_type                   drive_expected_q [$];

   fuzzy_pd_motor_velocity_controller dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_motor        (req_motor),
      .req_count_up     (req_count_up),
      .req_target_value (req_target_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_motor_id     (rsp_motor_id),
      .rsp_pwm_forward  (rsp_pwm_forward),
      .rsp_pwm_reverse  (rsp_pwm_reverse),
      .rsp_velocity     (rsp_velocity),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A requested hold-off keeps the receiver stalled while its count, loaded from hold_length, runs down.
   always @(posedge clock) begin
      if (hold_serial != hold_seen) begin
         hold_left = hold_length;
         hold_seen = hold_serial;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic int pick_min(int a, int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int pick_max(int a, int b);
      return (a > b) ? a : b;
   endfunction

   function automatic memb_type fuzzify_value(int v, int span);
      memb_type m;
      m = '0;
      if (v > span) begin
         m.p = MEMB_W'(span);
      end else if (v < -span) begin
         m.n = MEMB_W'(span);
      end else if (v > 0) begin
         m.p = MEMB_W'(v);
         m.z = MEMB_W'(span - v);
      end else begin
         m.n = MEMB_W'(-v);
         m.z = MEMB_W'(span + v);
      end
      return m;
   endfunction

   function automatic void reset_controller_model();
      for (int i = 0; i < GAIN_N; i++) begin
         cfg_reg[i] = GAIN_RESET[i];
      end
      cfg_reg[REG_TARGET_LIMIT] = CSR_DAT_W'(TARGET_LIMIT_RESET);
      cfg_reg[REG_MEMB_SPAN] = CSR_DAT_W'(MEMB_SPAN_RESET);
      for (int m = 0; m < MOTOR_COUNT_DEF; m++) begin
         tick_count[m] = '0;
         target_ticks[m] = '0;
         prev_error[m] = '0;
         last_correction[m] = 0;
         velocity_accum[m] = '0;
      end
   endfunction

   function automatic void predict_sample_tick();
      for (int m = 0; m < MOTOR_COUNT_DEF; m++) begin
         int err, del, span;
         int ps, pm, pl, ds, dm, dl;
         int e [3];
         int d [3];
         int r [3][3];
         memb_type me, md;
         longint pmul, dmul, psum, dsum, vsum;
         drive_type res;
         span = cfg_reg[REG_MEMB_SPAN];
         err = int'(target_ticks[m]) - int'(tick_count[m]);
         del = err - int'(prev_error[m]);
         prev_error[m] = 13'(err);
         tick_count[m] = '0;
         me = fuzzify_value(err, span);
         md = fuzzify_value(del, span);
         e[0] = me.n;
         e[1] = me.z;
         e[2] = me.p;
         d[0] = md.n;
         d[1] = md.z;
         d[2] = md.p;
         for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
               r[a][b] = pick_min(e[a], d[b]);
            end
         end
         ps = r[1][1];
         pm = pick_max(pick_max(pick_max(r[1][0], r[0][1]), pick_max(r[2][1], r[1][2])),
                       pick_max(r[0][0], r[2][2]));
         pl = pick_max(r[0][2], r[2][0]);
         ds = pick_max(pick_max(r[0][2], r[2][0]), r[1][1]);
         dm = pick_max(pick_max(r[0][0], r[0][1]), pick_max(r[2][1], r[2][2]));
         dl = pick_max(r[1][0], r[1][2]);
         pmul = longint'(ps) * longint'(cfg_reg[REG_KP_SMALL])
              + longint'(pm) * longint'(cfg_reg[REG_KP_MEDIUM])
              + longint'(pl) * longint'(cfg_reg[REG_KP_LARGE]);
         dmul = longint'(ds) * longint'(cfg_reg[REG_KD_SMALL])
              + longint'(dm) * longint'(cfg_reg[REG_KD_MEDIUM])
              + longint'(dl) * longint'(cfg_reg[REG_KD_LARGE]);
         psum = ps + pm + pl;
         dsum = ds + dm + dl;
         if (psum != 0 && dsum != 0) begin
            last_correction[m] = (longint'(err) * pmul) / psum
                               + (longint'(del) * dmul) / dsum;
         end
         vsum = longint'(velocity_accum[m]) + last_correction[m];
         if (vsum > PWM_MAX_DEF) begin
            vsum = PWM_MAX_DEF;
         end else if (vsum < -PWM_MAX_DEF) begin
            vsum = -PWM_MAX_DEF;
         end
         velocity_accum[m] = VEL_OUT_W'(vsum);
         res.motor_id = 1'(m);
         res.velocity = VEL_OUT_W'(vsum);
         if (vsum < 0) begin
            res.pwm_forward = '0;
            res.pwm_reverse = PWM_OUT_W'(-vsum);
         end else begin
            res.pwm_forward = PWM_OUT_W'(vsum);
            res.pwm_reverse = '0;
         end
         res.last = (m == MOTOR_COUNT_DEF - 1);
         drive_expected_q.push_back(res);
      end
   endfunction

   function automatic void apply_req(logic [CMD_W-1:0] cmd, logic motor, logic up,
                                     logic signed [TARGET_W-1:0] value);
      int tv, lim;
      tv = value;
      lim = cfg_reg[REG_TARGET_LIMIT];
      case (cmd)
         CMD_EDGE: begin
            if (up) begin
               if (tick_count[motor] < TICK_LIMIT_DEF) tick_count[motor] += 1;
            end else begin
               if (tick_count[motor] > -TICK_LIMIT_DEF) tick_count[motor] -= 1;
            end
         end
         CMD_TARGET: begin
            if (tv > lim) tv = lim;
            else if (tv < -lim) tv = -lim;
            target_ticks[motor] = TARGET_W'(tv);
         end
         CMD_TICK: begin
            predict_sample_tick();
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_req(logic [CMD_W-1:0] cmd, logic motor, logic up,
                           logic [TARGET_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_motor <= motor;
      req_count_up <= up;
      req_target_value <= value;
      do @(posedge clock); while (req_stall);
      apply_req(cmd, motor, up, value);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (drive_expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(reg_set_type vals);
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         if (i == REG_TARGET_LIMIT || i == REG_MEMB_SPAN) cfg_reg[i] = vals[i] & 8'h7f;
         else cfg_reg[i] = vals[i];
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_item();
      int pick;
      logic motor;
      logic up;
      logic [TARGET_W-1:0] value;
      pick = $urandom_range(99);
      motor = 1'($urandom_range(1));
      up = 1'($urandom_range(1));
      value = TARGET_W'($urandom_range(255));
      if (pick < 50) send_req(CMD_EDGE, motor, up, value);
      else if (pick < 72) send_req(CMD_TARGET, motor, up, value);
      else if (pick < 94) send_req(CMD_TICK, motor, up, value);
      else send_req(CMD_UNUSED, motor, up, value);
   endtask

   task automatic test_reset_defaults();
      send_req(CMD_TARGET, 1'b0, 1'b0, 8'sd127);
      send_req(CMD_TARGET, 1'b1, 1'b1, -8'sd128);
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      repeat (3) send_req(CMD_EDGE, 1'b0, 1'b1, 8'sd0);
      repeat (2) send_req(CMD_EDGE, 1'b1, 1'b0, 8'sd0);
      send_req(CMD_EDGE, 1'b1, 1'b1, 8'hff);
      send_req(CMD_UNUSED, 1'b1, 1'b1, 8'hff);
      send_req(CMD_TICK, 1'b1, 1'b1, 8'hff);
      send_req(CMD_TARGET, 1'b0, 1'b1, 8'sd0);
      send_req(CMD_TARGET, 1'b1, 1'b0, 8'sd4);
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      send_req(CMD_TARGET, 1'b0, 1'b0, -8'sd1);
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
   endtask

   task automatic test_tick_count_limits();
      for (int i = 0; i < EDGE_RUN; i++) begin
         send_req(CMD_EDGE, 1'b0, 1'b1, 8'sd0);
         send_req(CMD_EDGE, 1'b1, 1'b0, 8'sd0);
      end
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      for (int i = 0; i < EDGE_RUN; i++) begin
         send_req(CMD_EDGE, 1'b0, 1'b0, 8'sd0);
         send_req(CMD_EDGE, 1'b1, 1'b1, 8'sd0);
      end
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
   endtask

   task automatic test_gain_extremes();
      wait_for_drain();
      set_config('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
      send_req(CMD_TARGET, 1'b0, 1'b0, 8'sd127);
      send_req(CMD_TARGET, 1'b1, 1'b0, -8'sd128);
      repeat (3) send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      send_req(CMD_EDGE, 1'b1, 1'b0, 8'sd0);
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      wait_for_drain();
      set_config('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1});
      send_req(CMD_TARGET, 1'b0, 1'b0, 8'sd100);
      send_req(CMD_EDGE, 1'b1, 1'b1, 8'sd0);
      repeat (2) send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
   endtask

   // With a zero membership span every weight sum is zero, so the last
   // correction is applied again on each tick.
   task automatic test_zero_weight_sum();
      wait_for_drain();
      set_config('{8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd11, 8'd120, 8'd10});
      send_req(CMD_TARGET, 1'b0, 1'b0, 8'sd50);
      send_req(CMD_TARGET, 1'b1, 1'b0, -8'sd30);
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      wait_for_drain();
      set_config('{8'd9, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd120, 8'd0});
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      send_req(CMD_EDGE, 1'b0, 1'b1, 8'sd0);
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
   endtask

   task automatic test_backpressure();
      wait_for_drain();
      set_config('{8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd11, 8'd120, 8'd10});
      hold_length = HOLD_CYCLES;
      hold_serial++;
      send_req(CMD_TARGET, 1'b0, 1'b0, 8'sd20);
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      send_req(CMD_EDGE, 1'b0, 1'b1, 8'sd0);
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      send_req(CMD_TARGET, 1'b1, 1'b0, -8'sd7);
      send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
      wait_for_drain();
      repeat (3) send_req(CMD_TICK, 1'b0, 1'b0, 8'sd0);
   endtask

   task automatic test_random_phases();
      int idle_table [4];
      int stall_table [4];
      reg_set_type vals;
      idle_table = '{0, 50, 0, 19};
      stall_table = '{0, 0, 50, 19};
      for (int phase = 0; phase < 4; phase++) begin
         wait_for_drain();
         for (int i = 0; i < 8; i++) begin
            vals[i] = CSR_DAT_W'($urandom_range(255));
         end
         vals[REG_MEMB_SPAN] = CSR_DAT_W'($urandom_range(1, 127));
         set_config(vals);
         send_idle_pct = idle_table[phase];
         stall_pct = stall_table[phase];
         repeat (PHASE_ITEMS) send_random_item();
      end
   endtask

   always @(posedge clock) begin
      drive_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_expected_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("%0t: unexpected item for motor %0d", $realtime, rsp_motor_id);
            end
         end else begin
            want = drive_expected_q.pop_front();
            if (rsp_motor_id !== want.motor_id || rsp_pwm_forward !== want.pwm_forward ||
                rsp_pwm_reverse !== want.pwm_reverse || rsp_velocity !== want.velocity ||
                rsp_last !== want.last) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("%0t: expected motor %0d fwd %0d rev %0d vel %0d last %0d",
                           $realtime, want.motor_id, want.pwm_forward, want.pwm_reverse,
                           want.velocity, want.last);
                  $display("%0t: actual   motor %0d fwd %0d rev %0d vel %0d last %0d",
                           $realtime, rsp_motor_id, rsp_pwm_forward, rsp_pwm_reverse,
                           rsp_velocity, rsp_last);
               end
            end
         end
      end
   end

   initial begin
      reset_controller_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_tick_count_limits();
      test_gain_extremes();
      test_zero_weight_sum();
      test_backpressure();
      test_random_phases();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
